// ===== hw/rtl/fcull_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fcull_pkg
// shared constants and types for the six-plane frustum culling block
// ----------------------------------------------------------------------------
package fcull_pkg;

    // planes that take part in the test, and register slots that exist
    localparam int NUM_PLANES           = 6;
    localparam int PLANE_SLOTS          = 6;
    localparam int NORMAL_FRACTION_BITS = 14;

    // apb: 64-bit registers at byte address 8*i
    localparam int DATA_W = 64;
    localparam int ADDR_W = 6;
    localparam int IDX_W  = 3;

    // datapath widths
    localparam int COORD_W = 16;
    localparam int EXT_W   = 15;
    localparam int PROD_W  = 32;  // 16 x 16 signed product
    localparam int QPROD_W = 31;  // 15-bit extent x 16-bit magnitude
    localparam int PROJ_W  = 33;  // sum of three extent products
    localparam int SUM_W   = 37;  // distance plus offset, with headroom

    // query kinds
    localparam logic OP_SPHERE = 1'b0;
    localparam logic OP_BOX    = 1'b1;

    // per-stage load enables, shared by all plane lanes
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } t_pipe_ctl;

endpackage
`default_nettype wire

// ===== hw/rtl/fcull_plane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fcull_plane
// one plane lane: products, distance sums, and the cull decision
// ----------------------------------------------------------------------------
module fcull_plane
    import fcull_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire t_pipe_ctl                 i_ctl,
    input  wire logic [DATA_W-1:0]         i_plane,
    input  wire logic                      i_operation,
    input  wire logic signed [COORD_W-1:0] i_center_x,
    input  wire logic signed [COORD_W-1:0] i_center_y,
    input  wire logic signed [COORD_W-1:0] i_center_z,
    input  wire logic [EXT_W-1:0]          i_radius,
    input  wire logic [EXT_W-1:0]          i_half_x,
    input  wire logic [EXT_W-1:0]          i_half_y,
    input  wire logic [EXT_W-1:0]          i_half_z,
    output logic                           o_cull
);

    logic signed [COORD_W-1:0] w_nx, w_ny, w_nz, w_d;
    logic [COORD_W-1:0]        w_ax, w_ay, w_az;

    // stage 1
    logic signed [PROD_W-1:0] r_px, r_py, r_pz;
    logic [QPROD_W-1:0]       r_qx, r_qy, r_qz;
    logic signed [COORD_W-1:0] r_d1;
    logic                     r_op1;
    logic [EXT_W-1:0]         r_rad1;

    // stage 2
    logic signed [SUM_W-1:0] r_dist;
    logic [PROJ_W-1:0]       r_proj;
    logic                    r_op2;
    logic [EXT_W-1:0]        r_rad2;

    // stage 3
    logic                    r_cull;

    logic signed [SUM_W-1:0] n_dist;
    logic [PROJ_W-1:0]       n_proj;
    logic signed [SUM_W-1:0] w_add, w_tot;
    logic                    n_cull;

    assign w_nx = i_plane[15:0];
    assign w_ny = i_plane[31:16];
    assign w_nz = i_plane[47:32];
    assign w_d  = i_plane[63:48];

    // magnitude of a normal component; -32768 maps to 32768 unsigned
    assign w_ax = w_nx[COORD_W-1] ? (~w_nx + 1'b1) : w_nx;
    assign w_ay = w_ny[COORD_W-1] ? (~w_ny + 1'b1) : w_ny;
    assign w_az = w_nz[COORD_W-1] ? (~w_nz + 1'b1) : w_nz;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_px   <= w_nx * i_center_x;
            r_py   <= w_ny * i_center_y;
            r_pz   <= w_nz * i_center_z;
            r_qx   <= QPROD_W'(i_half_x) * QPROD_W'(w_ax);
            r_qy   <= QPROD_W'(i_half_y) * QPROD_W'(w_ay);
            r_qz   <= QPROD_W'(i_half_z) * QPROD_W'(w_az);
            r_d1   <= w_d;
            r_op1  <= i_operation;
            r_rad1 <= i_radius;
        end
    end

    always_comb begin
        n_dist = {{(SUM_W-PROD_W){r_px[PROD_W-1]}}, r_px}
               + {{(SUM_W-PROD_W){r_py[PROD_W-1]}}, r_py}
               + {{(SUM_W-PROD_W){r_pz[PROD_W-1]}}, r_pz}
               + {{(SUM_W-COORD_W-NORMAL_FRACTION_BITS){r_d1[COORD_W-1]}}, r_d1,
                  {NORMAL_FRACTION_BITS{1'b0}}};
        n_proj = PROJ_W'(r_qx) + PROJ_W'(r_qy) + PROJ_W'(r_qz);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en2) begin
            r_dist <= n_dist;
            r_proj <= n_proj;
            r_op2  <= r_op1;
            r_rad2 <= r_rad1;
        end
    end

    // box: dist + proj < 0; sphere: dist + radius <= 0 (radius scaled)
    always_comb begin
        if (r_op2 == OP_BOX) begin
            w_add = {{(SUM_W-PROJ_W){1'b0}}, r_proj};
        end else begin
            w_add = {{(SUM_W-EXT_W-NORMAL_FRACTION_BITS){1'b0}}, r_rad2,
                     {NORMAL_FRACTION_BITS{1'b0}}};
        end
        w_tot = r_dist + w_add;
        if (r_op2 == OP_BOX) begin
            n_cull = w_tot[SUM_W-1];
        end else begin
            n_cull = w_tot[SUM_W-1] || (w_tot == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en3) begin
            r_cull <= n_cull;
        end
    end

    assign o_cull = r_cull;

endmodule
`default_nettype wire

// ===== hw/rtl/frustum_cull_sphere_box.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frustum_cull_sphere_box
// sphere or box test against six configured frustum planes, one visible flag
// ----------------------------------------------------------------------------
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+------------------------------
//  query in  | in        | i_valid / o_stall     | operation, center, radius, half
//  result    | out       | o_valid / i_stall     | visible
//  config    | in        | apb psel/penable      | plane_0 .. plane_5 at 8*i
//
//  one item per cycle sustained while the output is not stalled; a result
//  passes four registers: products, sums, plane compare, output
//  synchronous active-low reset clears valids and all plane registers to zero
//  each stage holds while the one after it is full and stalled; bubbles
//  collapse, so items are still taken while a result waits at the output
// ----------------------------------------------------------------------------
module frustum_cull_sphere_box
    import fcull_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,

    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic                      i_operation,
    input  wire logic signed [COORD_W-1:0] i_center_x,
    input  wire logic signed [COORD_W-1:0] i_center_y,
    input  wire logic signed [COORD_W-1:0] i_center_z,
    input  wire logic [EXT_W-1:0]          i_radius,
    input  wire logic [EXT_W-1:0]          i_half_x,
    input  wire logic [EXT_W-1:0]          i_half_y,
    input  wire logic [EXT_W-1:0]          i_half_z,

    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic                           o_visible,

    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [ADDR_W-1:0]         paddr,
    input  wire logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]              prdata,
    output logic                           pready
);

    logic [DATA_W-1:0] r_plane [PLANE_SLOTS];
    logic [IDX_W-1:0]  w_idx;
    logic              w_wr;

    logic      r_v1, r_v2, r_v3, r_ov;
    logic      r_visible;
    logic      w_en_out;
    t_pipe_ctl w_ctl;
    logic [NUM_PLANES-1:0] w_cull;

    // ---------------- configuration
    assign pready = 1'b1;
    assign w_idx  = paddr[ADDR_W-1:ADDR_W-IDX_W];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PLANE_SLOTS; i++) begin
                r_plane[i] <= '0;
            end
        end else if (w_wr && (32'(w_idx) < PLANE_SLOTS)) begin
            r_plane[w_idx] <= pwdata;
        end
    end

    always_comb begin
        prdata = '0;
        if (32'(w_idx) < PLANE_SLOTS) begin
            prdata = r_plane[w_idx];
        end
    end

    // ---------------- pipeline control
    assign w_en_out  = !r_ov || !i_stall;
    assign w_ctl.en3 = !r_v3 || w_en_out;
    assign w_ctl.en2 = !r_v2 || w_ctl.en3;
    assign w_ctl.en1 = !r_v1 || w_ctl.en2;
    assign o_stall   = !w_ctl.en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_ctl.en1) begin
                r_v1 <= i_valid;
            end
            if (w_ctl.en2) begin
                r_v2 <= r_v1;
            end
            if (w_ctl.en3) begin
                r_v3 <= r_v2;
            end
            if (w_en_out) begin
                r_ov <= r_v3;
            end
        end
    end

    // ---------------- plane lanes
    for (genvar gi = 0; gi < NUM_PLANES; gi++) begin : g_plane
        fcull_plane u_plane (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_plane     (r_plane[gi]),
            .i_operation (i_operation),
            .i_center_x  (i_center_x),
            .i_center_y  (i_center_y),
            .i_center_z  (i_center_z),
            .i_radius    (i_radius),
            .i_half_x    (i_half_x),
            .i_half_y    (i_half_y),
            .i_half_z    (i_half_z),
            .o_cull      (w_cull[gi])
        );
    end

    // visible unless some plane culls
    always_ff @(posedge i_clk) begin
        if (w_en_out) begin
            r_visible <= ~|w_cull;
        end
    end

    assign o_valid   = r_ov;
    assign o_visible = r_visible;

    // ---------------- assertions
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && r_ov && i_stall))
        else $error("input stalled while pipeline has a free slot");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v1)
        else $error("accepted item did not enter stage 1");

    a_drain_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && w_en_out) |=> o_valid)
        else $error("stage 3 item lost on the way to the output");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !r_v1 && !r_v2 && !r_v3))
        else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

// ===== tb/sv/tb_frustum_cull_sphere_box.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frustum_cull_sphere_box
// self-checking bench for the six-plane sphere / box culling block
// ----------------------------------------------------------------------------
// a short directed table runs once on the reset planes, with expected flags
// typed in, and once on a fixed box frustum, checked by the local predictor.
// random segments follow, each on a freshly programmed plane set (frustum-like,
// raw random, extreme field values, sparse) and under one of four mixes of
// sender gaps and receiver stalls. planes are only rewritten once every
// pending result has drained, and each plane write is read back over apb.
// ----------------------------------------------------------------------------
module tb_frustum_cull_sphere_box;
    import fcull_pkg::*;

    localparam int DIRECTED_ROWS = 12;
    localparam int NUM_SEGMENTS  = 8;
    localparam int SEG_ITEMS     = 80;
    localparam int SETTLE_CYCLES = 8;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int Q_ONE         = 1 << NORMAL_FRACTION_BITS;

    typedef enum int {PL_FRONT, PL_BACK, PL_LEFT, PL_RIGHT, PL_TOP, PL_BOTTOM} t_plane_idx;
    typedef enum int {CFG_FRUSTUM, CFG_RAW, CFG_EXTREME, CFG_SPARSE} t_plane_mix;

    typedef struct packed {
        logic        op;
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] cz;
        logic [14:0] rad;
        logic [14:0] hx;
        logic [14:0] hy;
        logic [14:0] hz;
    } t_query;

    typedef struct packed {
        t_query q;
        logic   vis_at_reset;
    } t_directed_row;

    logic                      i_clk;
    logic                      i_rst_n     = 1'b0;
    logic                      i_valid     = 1'b0;
    logic                      o_stall;
    logic                      i_operation = OP_SPHERE;
    logic signed [COORD_W-1:0] i_center_x  = '0;
    logic signed [COORD_W-1:0] i_center_y  = '0;
    logic signed [COORD_W-1:0] i_center_z  = '0;
    logic [EXT_W-1:0]          i_radius    = '0;
    logic [EXT_W-1:0]          i_half_x    = '0;
    logic [EXT_W-1:0]          i_half_y    = '0;
    logic [EXT_W-1:0]          i_half_z    = '0;
    logic                      o_valid;
    logic                      i_stall     = 1'b0;
    logic                      o_visible;
    logic                      psel        = 1'b0;
    logic                      penable     = 1'b0;
    logic                      pwrite      = 1'b0;
    logic [ADDR_W-1:0]         paddr       = '0;
    logic [DATA_W-1:0]         pwdata      = '0;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;

    frustum_cull_sphere_box dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_center_z  (i_center_z),
        .i_radius    (i_radius),
        .i_half_x    (i_half_x),
        .i_half_y    (i_half_y),
        .i_half_z    (i_half_z),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_visible   (o_visible),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // shadow of the plane registers and the set about to be programmed
    logic [DATA_W-1:0] plane_q    [PLANE_SLOTS];
    logic [DATA_W-1:0] plane_next [PLANE_SLOTS];

    bit vis_expected [$];
    bit exp_vis;

    int idle_pct  = 0;
    int stall_pct = 0;
    int cycle_cnt = 0;
    int err_cnt   = 0;
    int n_sphere  = 0;
    int n_box     = 0;
    int n_vis     = 0;
    int n_culled  = 0;
    int n_writes  = 0;

    // typed flags hold for the all-zero reset planes: distance is always 0
    t_directed_row dir_tbl [DIRECTED_ROWS] = '{
        '{'{OP_SPHERE, 16'h0000, 16'h0000, 16'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000}, 1'b0},
        '{'{OP_SPHERE, 16'h0000, 16'h0000, 16'h0000, 15'h0001, 15'h0000, 15'h0000, 15'h0000}, 1'b1},
        '{'{OP_SPHERE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h7FFF, 15'h0000, 15'h0000, 15'h0000}, 1'b1},
        '{'{OP_SPHERE, 16'h8000, 16'h8000, 16'h8000, 15'h0000, 15'h7FFF, 15'h7FFF, 15'h7FFF}, 1'b0},
        '{'{OP_BOX,    16'h0000, 16'h0000, 16'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000}, 1'b1},
        '{'{OP_BOX,    16'h8000, 16'h8000, 16'h8000, 15'h7FFF, 15'h0000, 15'h0000, 15'h0000}, 1'b1},
        '{'{OP_BOX,    16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h0000, 15'h7FFF, 15'h7FFF, 15'h7FFF}, 1'b1},
        '{'{OP_SPHERE, 16'h7FFF, 16'h8000, 16'h0000, 15'h5555, 15'h2AAA, 15'h0000, 15'h0000}, 1'b1},
        '{'{OP_BOX,    16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h0000, 15'h2AAA, 15'h5555, 15'h7FFF}, 1'b1},
        // touching the front plane of the box frustum: x = -1010, d = 1000
        '{'{OP_SPHERE, 16'hFC0E, 16'h0000, 16'h0000, 15'd10,   15'h0000, 15'h0000, 15'h0000}, 1'b1},
        '{'{OP_BOX,    16'hFC0E, 16'h0000, 16'h0000, 15'h0000, 15'd10,   15'h0000, 15'h0000}, 1'b1},
        '{'{OP_BOX,    16'hFC0E, 16'h0000, 16'h0000, 15'h0000, 15'd9,    15'h0000, 15'h0000}, 1'b1}
    };

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("timeout with %0d results outstanding", vis_expected.size());
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= i_rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (vis_expected.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending, visible=%b", o_visible));
            end else begin
                exp_vis = vis_expected.pop_front();
                if (o_visible !== exp_vis) begin
                    report_mismatch($sformatf("visible=%b, predicted %b", o_visible, exp_vis));
                end
                if (o_visible === 1'b1) n_vis++;
                else n_culled++;
            end
        end
    end

    function automatic logic [DATA_W-1:0] pack_plane(logic [15:0] nx, logic [15:0] ny,
                                                     logic [15:0] nz, logic [15:0] d);
        return {d, nz, ny, nx};
    endfunction

    // exact plane test at full precision, normal in Q1.14, offset in coordinate units
    function automatic bit predict_visible(t_query q);
        longint scale, cx, cy, cz, r, hx, hy, hz;
        longint nx, ny, nz, d, pdist, proj;
        bit     vis;
        int     i;
        vis   = 1'b1;
        scale = Q_ONE;
        cx    = $signed(q.cx);
        cy    = $signed(q.cy);
        cz    = $signed(q.cz);
        r     = q.rad;
        hx    = q.hx;
        hy    = q.hy;
        hz    = q.hz;
        for (i = 0; i < NUM_PLANES; i++) begin
            nx    = $signed(plane_q[i][15:0]);
            ny    = $signed(plane_q[i][31:16]);
            nz    = $signed(plane_q[i][47:32]);
            d     = $signed(plane_q[i][63:48]);
            pdist = nx * cx + ny * cy + nz * cz + d * scale;
            if (q.op == OP_BOX) begin
                proj = hx * (nx < 0 ? -nx : nx) + hy * (ny < 0 ? -ny : ny)
                     + hz * (nz < 0 ? -nz : nz);
                if (pdist + proj < 0) vis = 1'b0;
            end else if (pdist <= -(r * scale)) begin
                vis = 1'b0;
            end
        end
        return vis;
    endfunction

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 7))
            0:             return pick_extreme();
            1, 2, 3, 4:    return 16'($urandom_range(0, 3000) - 1500);
            default:       return 16'($urandom);
        endcase
    endfunction

    function automatic logic [14:0] rand_extent();
        case ($urandom_range(0, 7))
            0:             return $urandom_range(0, 1) ? 15'h7FFF : 15'h0000;
            1, 2, 3, 4, 5: return 15'($urandom_range(0, 500));
            default:       return 15'($urandom);
        endcase
    endfunction

    function automatic t_query rand_query();
        t_query q;
        q.op  = $urandom_range(0, 1) ? OP_BOX : OP_SPHERE;
        q.cx  = rand_coord();
        q.cy  = rand_coord();
        q.cz  = rand_coord();
        q.rad = rand_extent();
        q.hx  = rand_extent();
        q.hy  = rand_extent();
        q.hz  = rand_extent();
        return q;
    endfunction

    // axis planes: index / 2 picks the axis, odd index faces the negative way
    function automatic logic [DATA_W-1:0] axis_plane(int idx, logic [15:0] d);
        logic [15:0] n [3];
        n = '{16'h0000, 16'h0000, 16'h0000};
        n[idx / 2] = (idx % 2) ? 16'(-Q_ONE) : 16'(Q_ONE);
        return pack_plane(n[0], n[1], n[2], d);
    endfunction

    task automatic fill_planes(input t_plane_mix mix);
        int i;
        for (i = 0; i < PLANE_SLOTS; i++) begin
            case (mix)
                CFG_FRUSTUM: begin
                    if ($urandom_range(0, 1)) begin
                        plane_next[i] = pack_plane(16'($urandom_range(0, 2 * Q_ONE) - Q_ONE),
                                                   16'($urandom_range(0, 2 * Q_ONE) - Q_ONE),
                                                   16'($urandom_range(0, 2 * Q_ONE) - Q_ONE),
                                                   16'($urandom_range(0, 1500)));
                    end else begin
                        plane_next[i] = axis_plane(i, 16'($urandom_range(0, 1500)));
                    end
                end
                CFG_RAW: begin
                    plane_next[i] = ($urandom_range(0, 3) == 0) ? '0 : {$urandom, $urandom};
                end
                CFG_EXTREME: begin
                    plane_next[i] = pack_plane(pick_extreme(), pick_extreme(),
                                               pick_extreme(), pick_extreme());
                end
                default: begin
                    plane_next[i] = $urandom_range(0, 1) ? '0 :
                                    axis_plane($urandom_range(0, PLANE_SLOTS - 1),
                                               16'($urandom_range(0, 300)));
                end
            endcase
        end
    endtask

    // transfers run back to back with psel held; the caller releases the bus
    task automatic apb_cycle(input logic wr, input int idx, input logic [DATA_W-1:0] wdata,
                             output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_W'(idx * 8);
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata   = prdata;
    endtask

    // writes beyond the last slot must leave every plane untouched
    task automatic program_planes(input bit hit_unused);
        logic [DATA_W-1:0] rd;
        int                i;
        for (i = 0; i < (1 << IDX_W); i++) begin
            if (i < PLANE_SLOTS) begin
                apb_cycle(1'b1, i, plane_next[i], rd);
                plane_q[i] = plane_next[i];
                n_writes++;
            end else if (hit_unused) begin
                apb_cycle(1'b1, i, {$urandom, $urandom}, rd);
            end
        end
        for (i = 0; i < PLANE_SLOTS; i++) begin
            apb_cycle(1'b0, i, '0, rd);
            if (rd !== plane_q[i]) begin
                report_mismatch($sformatf("plane %0d reads %h, wrote %h", i, rd, plane_q[i]));
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_query(input t_query q, input bit vis);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= q.op;
        i_center_x  <= q.cx;
        i_center_y  <= q.cy;
        i_center_z  <= q.cz;
        i_radius    <= q.rad;
        i_half_x    <= q.hx;
        i_half_y    <= q.hy;
        i_half_z    <= q.hz;
        do @(posedge i_clk); while (o_stall);
        vis_expected.push_back(vis);
        if (q.op == OP_BOX) n_box++;
        else n_sphere++;
    endtask

    task automatic drain_and_settle();
        i_valid <= 1'b0;
        while (vis_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int     k;
        int     seg;
        t_query q;
        for (k = 0; k < PLANE_SLOTS; k++) plane_q[k] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset planes: flags read straight off the table
        for (k = 0; k < DIRECTED_ROWS; k++) begin
            send_query(dir_tbl[k].q, dir_tbl[k].vis_at_reset);
        end

        // same rows against a box frustum around the origin
        drain_and_settle();
        plane_next[PL_FRONT]  = axis_plane(PL_FRONT, 16'd1000);
        plane_next[PL_BACK]   = axis_plane(PL_BACK, 16'd1000);
        plane_next[PL_LEFT]   = axis_plane(PL_LEFT, 16'd800);
        plane_next[PL_RIGHT]  = axis_plane(PL_RIGHT, 16'd800);
        plane_next[PL_TOP]    = axis_plane(PL_TOP, 16'd200);
        plane_next[PL_BOTTOM] = axis_plane(PL_BOTTOM, 16'd2000);
        program_planes(1'b0);
        for (k = 0; k < DIRECTED_ROWS; k++) begin
            send_query(dir_tbl[k].q, predict_visible(dir_tbl[k].q));
        end

        for (seg = 0; seg < NUM_SEGMENTS; seg++) begin
            drain_and_settle();
            fill_planes(t_plane_mix'(seg % 4));
            program_planes(seg == 4);
            case ((seg + seg / 4) % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 83; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 83; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            for (k = 0; k < SEG_ITEMS; k++) begin
                // hold the sender mid-stream until the pipe is empty
                if (seg == 3 && k == SEG_ITEMS / 2) drain_and_settle();
                q = rand_query();
                send_query(q, predict_visible(q));
            end
        end

        drain_and_settle();
        $display("ran %0d sphere and %0d box queries: %0d visible, %0d culled",
                 n_sphere, n_box, n_vis, n_culled);
        $display("planes rewritten %0d times across frustum, raw, extreme and sparse sets",
                 n_writes);
        if (err_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/fcull_pkg.sv
hw/rtl/fcull_plane.sv
hw/rtl/frustum_cull_sphere_box.sv
tb/sv/tb_frustum_cull_sphere_box.sv
